// File: hw/rtl/lccp_pkg.sv
`default_nettype none

package lccp_pkg;

  localparam int unsigned COEF_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAX_D = 11;
  localparam int unsigned NUM_W = COEF_W + MAX_D;
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP_W = 24;
  localparam int unsigned REM_W = COEF_W + 1;
  localparam int unsigned PEND_W = 7;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned TOT_W = 5;
  localparam int unsigned ACC_W = PEND_W + MAX_D;

  localparam int unsigned MODULUS_DEF = 3329;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic MODE_D10 = 1'b0;
  localparam logic MODE_D11 = 1'b1;

  localparam logic [TOT_W-1:0] D_NARROW = 5'd10;
  localparam logic [TOT_W-1:0] D_WIDE = 5'd11;

  localparam logic [MAX_D-1:0] MASK_D10 = 11'h3ff;
  localparam logic [MAX_D-1:0] MASK_D11 = 11'h7ff;

  typedef struct packed {
    logic             mode;
    logic [MAX_D-1:0] bits;
  } coef_t;

endpackage

`default_nettype wire

// File: hw/rtl/lccp_front.sv
`default_nettype none

module lccp_front #(
  parameter int unsigned MODULUS = lccp_pkg::MODULUS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lccp_pkg::COEF_W-1:0]  coefficient_i,
  input  wire logic                         mode_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lccp_pkg::coef_t                   out_entry_o
);

  localparam int unsigned NW = lccp_pkg::NUM_W;
  localparam int unsigned RW = lccp_pkg::RECIP_W;
  localparam int unsigned PW = NW + RW;
  localparam int unsigned QMW = NW + lccp_pkg::COEF_W;
  localparam int unsigned DW = lccp_pkg::MAX_D;
  localparam int unsigned EW = lccp_pkg::REM_W;
  localparam int unsigned HalfMod = MODULUS / 2;
  localparam logic [RW-1:0] Recip = RW'((64'd1 << lccp_pkg::RECIP_SH) / MODULUS);

  // stage 1: numerator and reciprocal product
  logic          v1_q;
  logic [NW-1:0] num1_q, num_d;
  logic [PW-1:0] prod1_q, prod_d;
  logic          mode1_q;
  logic          rdy1;

  // stage 2: quotient estimate and remainder
  logic          v2_q;
  logic [DW-1:0] qlo2_q;
  logic [EW-1:0] rem2_q;
  logic          mode2_q;
  logic          rdy2;

  logic [NW-1:0]  q_est;
  logic [QMW-1:0] qm;
  logic [NW-1:0]  rem_full;
  logic           inc;
  logic [DW-1:0]  q_fix;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    if (mode_i == lccp_pkg::MODE_D11) begin
      num_d = {coefficient_i, 11'b0};
    end else begin
      num_d = {1'b0, coefficient_i, 10'b0};
    end
    num_d  = num_d + NW'(HalfMod);
    prod_d = PW'(num_d) * PW'(Recip);
  end

  assign q_est    = prod1_q[lccp_pkg::RECIP_SH +: NW];
  assign qm       = QMW'(q_est) * QMW'(MODULUS);
  assign rem_full = num1_q - qm[NW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      num1_q  <= num_d;
      prod1_q <= prod_d;
      mode1_q <= mode_i;
    end
    if (rdy2 && v1_q) begin
      qlo2_q  <= q_est[DW-1:0];
      rem2_q  <= rem_full[EW-1:0];
      mode2_q <= mode1_q;
    end
  end

  assign inc   = rem2_q >= EW'(MODULUS);
  assign q_fix = qlo2_q + DW'(inc);

  always_comb begin
    out_entry_o.mode = mode2_q;
    if (mode2_q == lccp_pkg::MODE_D11) begin
      out_entry_o.bits = q_fix & lccp_pkg::MASK_D11;
    end else begin
      out_entry_o.bits = q_fix & lccp_pkg::MASK_D10;
    end
  end

  assign out_valid_o = v2_q;

endmodule

`default_nettype wire

// File: hw/rtl/lccp_fifo.sv
`default_nettype none

module lccp_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire lccp_pkg::coef_t  wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output lccp_pkg::coef_t       rd_data_o
);

  localparam int unsigned QD = lccp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTW = lccp_pkg::QPTR_W;
  localparam int unsigned CW = lccp_pkg::QCNT_W;

  lccp_pkg::coef_t mem_q [QD];
  logic [PTW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = cnt_q != CW'(QD);
  assign rd_valid_o = cnt_q != '0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_ready_i && rd_valid_o;
  assign cnt_d = cnt_q + CW'(push) - CW'(pop);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + PTW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QD))
    else $error("queue fill count past depth");

endmodule

`default_nettype wire

// File: hw/rtl/lccp_back.sv
`default_nettype none

module lccp_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lccp_pkg::coef_t              in_entry_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lccp_pkg::BYTE_W-1:0]       packed_byte_o,
  output logic                              last_of_run_o
);

  localparam int unsigned AW = lccp_pkg::ACC_W;
  localparam int unsigned TW = lccp_pkg::TOT_W;
  localparam int unsigned PBW = lccp_pkg::PEND_W;
  localparam int unsigned CW = lccp_pkg::CNT_W;
  localparam int unsigned BW = lccp_pkg::BYTE_W;

  logic [PBW-1:0] pend_bits_q;
  logic [CW-1:0]  pend_cnt_q;
  logic           hold_q;
  logic [BW-1:0]  hold_byte_q;
  logic           out_valid_q;
  logic [BW-1:0]  out_byte_q;
  logic           out_last_q;

  logic          load;
  logic [TW-1:0] d;
  logic [TW-1:0] total;
  logic [AW-1:0] acc;
  logic          two;

  assign load = !out_valid_q || out_ready_i;
  assign in_ready_o = load && !hold_q;

  always_comb begin
    if (in_entry_i.mode == lccp_pkg::MODE_D11) begin
      d = lccp_pkg::D_WIDE;
    end else begin
      d = lccp_pkg::D_NARROW;
    end
    total = TW'(pend_cnt_q) + d;
    acc   = (AW'(in_entry_i.bits) << pend_cnt_q) | AW'(pend_bits_q);
    two   = total[TW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      if (hold_q) begin
        hold_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (in_valid_i) begin
        hold_q      <= two;
        out_valid_q <= 1'b1;
        pend_cnt_q  <= total[CW-1:0];
        if (two) begin
          pend_bits_q <= PBW'(acc[AW-1:2*BW]);
        end else begin
          pend_bits_q <= acc[BW +: PBW];
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (hold_q) begin
        out_byte_q <= hold_byte_q;
        out_last_q <= 1'b1;
      end else if (in_valid_i) begin
        out_byte_q  <= acc[BW-1:0];
        out_last_q  <= !two;
        hold_byte_q <= acc[BW +: BW];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;
  assign last_of_run_o = out_last_q;

  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> out_valid_q && !out_last_q)
    else $error("second byte held without first byte on output");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(hold_q) |-> out_valid_q && out_last_q)
    else $error("second byte not shown after release");

  a_first_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> hold_q)
    else $error("non-final byte without a following byte");

endmodule

`default_nettype wire

// File: hw/rtl/lattice_coeff_compress_pack.sv
// Compress-and-pack for lattice polynomial coefficients.
// Input channel: one 12-bit coefficient per beat (in_valid_i / in_ready_o).
// Each coefficient is compressed to 10 or 11 bits, per the width mode
// register, and appended LSB first to a bit accumulator; every complete
// byte leaves on the output channel (out_valid_o / out_ready_i) with
// last_of_run_o set on the final byte of that coefficient (one or two bytes).
// Config: cfg_we_i writes cfg_wdata_i into the width mode register; write
// only while the block is idle.
// Path: an accepted input beat passes the two reciprocal divider stages, one
// queue slot and the output register before its first byte is valid.
// Throughput: one output byte per cycle while out_ready_i is high, set by the
// packer's single output port; a two-byte coefficient holds off the next one.
// A two-entry queue parts the divider pipeline from the packer, so input
// keeps flowing while the output is stalled until the queue and stages fill.
// Reset clears the mode (10-bit), the accumulator and all valid state.
`default_nettype none

module lattice_coeff_compress_pack #(
  parameter int unsigned MODULUS = lccp_pkg::MODULUS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lccp_pkg::COEF_W-1:0]  coefficient_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lccp_pkg::BYTE_W-1:0]       packed_byte_o,
  output logic                              last_of_run_o
);

  logic            width_mode_q;
  logic            f_valid, f_ready;
  lccp_pkg::coef_t f_entry;
  logic            q_valid, q_ready;
  lccp_pkg::coef_t q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q <= lccp_pkg::MODE_D10;
    end else if (cfg_we_i) begin
      width_mode_q <= cfg_wdata_i;
    end
  end

  lccp_front #(
    .MODULUS(MODULUS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coefficient_i(coefficient_i),
    .mode_i       (width_mode_q),
    .out_valid_o  (f_valid),
    .out_ready_i  (f_ready),
    .out_entry_o  (f_entry)
  );

  lccp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_entry),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_entry)
  );

  lccp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_entry_i   (q_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .packed_byte_o(packed_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire
